>>> rtl/assert_macros.svh
// Assertion macros used by the suffix automaton builder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert that a property holds on every clock edge outside reset.
`define SAB_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Assert that an antecedent implies a consequent on the following clock edge.
`define SAB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/sab_pkg.sv
// ----------------------------------------------------------------------------
// sab_pkg
// Constants, types and codes shared by the suffix automaton builder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package sab_pkg;
  localparam int unsigned MaxNodes  = 2048;
  localparam int unsigned Alphabet  = 26;
  localparam int unsigned NodeW     = $clog2(MaxNodes);
  localparam int unsigned CountW    = NodeW + 1;
  localparam int unsigned SymW      = 5;
  localparam int unsigned TransDepth = MaxNodes * Alphabet;
  localparam int unsigned TransAw   = $clog2(TransDepth);

  typedef enum logic [1:0] {
    CMD_INIT   = 2'd0,
    CMD_EXTEND = 2'd1,
    CMD_RDTRAN = 2'd2,
    CMD_RDNODE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_BADNODE = 2'd2
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_ROOT_CLR,
    S_RD_LAST,
    S_NEW_CLR,
    S_WALK_RD,
    S_WALK_CHK,
    S_WALK_LNK,
    S_Q_RD,
    S_Q_CHK,
    S_CL_RD,
    S_CL_WR,
    S_CL_META,
    S_RW_RD,
    S_RW_CHK,
    S_RW_LNK,
    S_FIN_RD,
    S_FIN,
    S_RD_WAIT,
    S_OUT
  } state_e;

  // Row base of a node in the transition store: node * Alphabet.
  function automatic logic [TransAw-1:0] row_base(input logic [NodeW-1:0] n);
    row_base = TransAw'(n) * TransAw'(Alphabet);
  endfunction
endpackage
`default_nettype wire

>>> rtl/sab_ram.sv
// ----------------------------------------------------------------------------
// sab_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module sab_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // Write when enabled; read data is registered (old data on a write)
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

>>> rtl/suffix_automaton_builder.sv
// ----------------------------------------------------------------------------
// suffix_automaton_builder
// Online suffix automaton construction over a 26-letter alphabet.
// ----------------------------------------------------------------------------
// channel  | direction | handshake
// request  | in        | req_valid_i / req_stall_o
// result   | out       | res_valid_o / res_stall_i
//
// One request at a time. A read presents its addresses, then reports; a bad node
// index is reported at once. Extend works through the single port of the
// transition store: new row, suffix-link walk, target check, and for a clone a
// row copy and edge redirects. Refused or no-letter extends end early.
// Initialise and reset clear the root row; after reset requests are held off.
// The result register waits under res_stall_i; the next request is taken
// only once the previous result has gone.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module suffix_automaton_builder
  import sab_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                req_valid_i,
  output logic                     req_stall_o,
  input  wire logic [1:0]          command_i,
  input  wire logic [SymW-1:0]     symbol_i,
  input  wire logic [NodeW-1:0]    node_index_i,
  output logic                     res_valid_o,
  input  wire logic                res_stall_i,
  output logic      [1:0]          status_o,
  output logic      [NodeW-1:0]    target_node_o,
  output logic      [NodeW-1:0]    link_node_o,
  output logic      [NodeW-1:0]    node_length_o,
  output logic                     clone_made_o,
  output logic      [NodeW-1:0]    clone_node_o,
  output logic      [CountW-1:0]   node_count_o
);
  state_e state_q, state_d;

  // Stores
  logic               tr_we, lk_we, ln_we;
  logic [TransAw-1:0] tr_addr;
  logic [NodeW-1:0]   tr_wdata, tr_rdata;
  logic [NodeW-1:0]   lk_addr, lk_wdata, lk_rdata;
  logic [NodeW-1:0]   ln_addr, ln_wdata, ln_rdata;

  sab_ram #(.Width(NodeW), .Depth(TransDepth)) u_tr (
    .clk_i, .we_i(tr_we), .addr_i(tr_addr), .wdata_i(tr_wdata), .rdata_o(tr_rdata));
  sab_ram #(.Width(NodeW), .Depth(MaxNodes)) u_lk (
    .clk_i, .we_i(lk_we), .addr_i(lk_addr), .wdata_i(lk_wdata), .rdata_o(lk_rdata));
  sab_ram #(.Width(NodeW), .Depth(MaxNodes)) u_ln (
    .clk_i, .we_i(ln_we), .addr_i(ln_addr), .wdata_i(ln_wdata), .rdata_o(ln_rdata));

  // Working registers
  logic [1:0]        cmd_q, cmd_d;
  logic [SymW-1:0]   sym_q, sym_d;
  logic [NodeW-1:0]  idx_q, idx_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic [NodeW-1:0]  last_q, last_d;
  logic [NodeW-1:0]  cur_q, cur_d, nw_q, nw_d, q_q, q_d, cl_q, cl_d;
  logic [NodeW-1:0]  curlen_q, curlen_d, newlen_q, newlen_d;
  logic [SymW-1:0]   e_q, e_d;
  logic              pend_q, pend_d;
  logic [NodeW-1:0]  pdat_q, pdat_d;
  logic              res_v_q, res_v_d;
  logic [1:0]        st_q, st_d;
  logic [NodeW-1:0]  tgt_q, tgt_d, lnk_q, lnk_d, len_q, len_d, cn_q, cn_d;
  logic              cm_q, cm_d;

  logic              accept;
  logic              sym_ok;

  assign accept   = req_valid_i && !req_stall_o;
  assign req_stall_o = (state_q != S_IDLE) || res_v_q;
  assign sym_ok   = sym_q < SymW'(Alphabet);

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_ROOT_CLR;
      cmd_q   <= CMD_RDNODE;
      cnt_q   <= CountW'(1);
      last_q  <= '0;
      e_q     <= '0;
      res_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cmd_q   <= cmd_d;
      cnt_q   <= cnt_d;
      last_q  <= last_d;
      e_q     <= e_d;
      res_v_q <= res_v_d;
    end
  end

  // Hold payload
  always_ff @(posedge clk_i) begin
    sym_q <= sym_d; idx_q <= idx_d;
    cur_q <= cur_d; nw_q <= nw_d; q_q <= q_d; cl_q <= cl_d;
    curlen_q <= curlen_d; newlen_q <= newlen_d;
    pend_q <= pend_d; pdat_q <= pdat_d;
    st_q <= st_d; tgt_q <= tgt_d; lnk_q <= lnk_d; len_q <= len_d;
    cm_q <= cm_d; cn_q <= cn_d;
  end

  // Sequence the stores
  always_comb begin
    state_d = state_q;
    cmd_d = cmd_q; sym_d = sym_q; idx_d = idx_q;
    cnt_d = cnt_q; last_d = last_q;
    cur_d = cur_q; nw_d = nw_q; q_d = q_q; cl_d = cl_q;
    curlen_d = curlen_q; newlen_d = newlen_q; e_d = e_q;
    pend_d = pend_q; pdat_d = pdat_q;
    res_v_d = res_v_q;
    st_d = st_q; tgt_d = tgt_q; lnk_d = lnk_q; len_d = len_q;
    cm_d = cm_q; cn_d = cn_q;
    tr_we = 1'b0; tr_addr = '0; tr_wdata = '0;
    lk_we = 1'b0; lk_addr = '0; lk_wdata = '0;
    ln_we = 1'b0; ln_addr = '0; ln_wdata = '0;

    if (res_v_q && !res_stall_i) begin
      res_v_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_d = command_i; sym_d = symbol_i; idx_d = node_index_i;
          st_d = ST_OK; tgt_d = '0; lnk_d = '0; len_d = '0;
          cm_d = 1'b0; cn_d = '0; e_d = '0;
          unique case (cmd_e'(command_i))
            CMD_INIT: begin
              cnt_d = CountW'(1); last_d = '0;
              state_d = S_ROOT_CLR;
            end
            CMD_EXTEND: begin
              if (cnt_q + CountW'(2) > CountW'(MaxNodes)) begin
                st_d = ST_FULL; state_d = S_OUT;
              end else begin
                state_d = S_RD_LAST;
              end
            end
            default: begin
              if (CountW'(node_index_i) >= cnt_q) begin
                st_d = ST_BADNODE; state_d = S_OUT;
              end else begin
                state_d = S_RD_WAIT;
              end
            end
          endcase
        end
      end
      // Clear the root row, link and length; report only for an initialise request
      S_ROOT_CLR: begin
        tr_we = 1'b1; tr_addr = TransAw'(e_q);
        lk_we = 1'b1; ln_we = 1'b1;
        if (e_q == SymW'(Alphabet - 1)) begin
          e_d = '0;
          state_d = (cmd_q == CMD_INIT) ? S_OUT : S_IDLE;
        end else begin
          e_d = e_q + SymW'(1);
        end
      end
      // Read last node link and length
      S_RD_LAST: begin
        lk_addr = last_q; ln_addr = last_q;
        state_d = S_NEW_CLR;
        e_d = '0;
      end
      S_NEW_CLR: begin
        if (e_q == '0) begin
          curlen_d = ln_rdata; newlen_d = ln_rdata + NodeW'(1);
          lnk_d = lk_rdata;
          if (!sym_ok) begin
            tgt_d = last_q; len_d = ln_rdata; state_d = S_OUT;
          end
        end
        if (sym_ok) begin
          nw_d = cnt_q[NodeW-1:0];
          tr_we = 1'b1;
          tr_addr = row_base(cnt_q[NodeW-1:0]) + TransAw'(e_q);
          if (e_q == SymW'(Alphabet - 1)) begin
            ln_we = 1'b1; ln_addr = cnt_q[NodeW-1:0]; ln_wdata = newlen_q;
            cnt_d = cnt_q + CountW'(1);
            last_d = cnt_q[NodeW-1:0];
            cur_d = last_q;
            state_d = S_WALK_RD;
          end else begin
            e_d = e_q + SymW'(1);
          end
        end
      end
      // Walk suffix links, setting missing edges
      S_WALK_RD: begin
        tr_addr = row_base(cur_q) + TransAw'(sym_q);
        ln_addr = cur_q; lk_addr = cur_q;
        state_d = S_WALK_CHK;
      end
      S_WALK_CHK: begin
        curlen_d = ln_rdata;
        if (tr_rdata != '0) begin
          q_d = tr_rdata;
          state_d = S_Q_RD;
        end else begin
          tr_we = 1'b1; tr_addr = row_base(cur_q) + TransAw'(sym_q); tr_wdata = nw_q;
          if (cur_q == '0) begin
            pdat_d = '0; state_d = S_FIN;
          end else begin
            cur_d = lk_rdata; state_d = S_WALK_RD;
          end
        end
      end
      S_Q_RD: begin
        ln_addr = q_q; lk_addr = q_q;
        state_d = S_Q_CHK;
      end
      S_Q_CHK: begin
        if (ln_rdata == curlen_q + NodeW'(1)) begin
          pdat_d = q_q; state_d = S_FIN;
        end else begin
          cl_d = cnt_q[NodeW-1:0];
          cnt_d = cnt_q + CountW'(1);
          pdat_d = lk_rdata;
          e_d = '0;
          state_d = S_CL_RD;
        end
      end
      // Copy the edges of q into the clone
      S_CL_RD: begin
        tr_addr = row_base(q_q) + TransAw'(e_q);
        state_d = S_CL_WR;
      end
      S_CL_WR: begin
        tr_we = 1'b1; tr_addr = row_base(cl_q) + TransAw'(e_q); tr_wdata = tr_rdata;
        if (e_q == SymW'(Alphabet - 1)) begin
          e_d = '0; state_d = S_CL_META;
        end else begin
          e_d = e_q + SymW'(1); state_d = S_CL_RD;
        end
      end
      S_CL_META: begin
        ln_we = 1'b1; ln_addr = cl_q; ln_wdata = curlen_q + NodeW'(1);
        lk_we = 1'b1; lk_addr = cl_q; lk_wdata = pdat_q;
        state_d = S_RW_RD;
      end
      // Redirect edges to the clone
      S_RW_RD: begin
        tr_addr = row_base(cur_q) + TransAw'(sym_q);
        lk_addr = cur_q;
        if (pend_q) begin
          lk_we = 1'b0;
        end
        state_d = S_RW_CHK;
      end
      S_RW_CHK: begin
        if (tr_rdata != q_q) begin
          state_d = S_RW_LNK;
        end else begin
          tr_we = 1'b1; tr_addr = row_base(cur_q) + TransAw'(sym_q); tr_wdata = cl_q;
          if (cur_q == '0) begin
            state_d = S_RW_LNK;
          end else begin
            cur_d = lk_rdata; state_d = S_RW_RD;
          end
        end
      end
      S_RW_LNK: begin
        lk_we = 1'b1; lk_addr = q_q; lk_wdata = cl_q;
        cm_d = 1'b1; cn_d = cl_q; pdat_d = cl_q;
        state_d = S_FIN;
      end
      S_FIN: begin
        lk_we = 1'b1; lk_addr = nw_q; lk_wdata = pdat_q;
        tgt_d = nw_q; lnk_d = pdat_q; len_d = newlen_q;
        state_d = S_OUT;
      end
      S_FIN_RD: begin
        state_d = S_OUT;
      end
      // Read request: address presented in this cycle
      S_RD_WAIT: begin
        tr_addr = row_base(idx_q) + TransAw'(sym_q);
        lk_addr = idx_q; ln_addr = idx_q;
        state_d = S_FIN_RD;
        pend_d = 1'b1;
      end
      S_OUT: begin
        if (pend_q) begin
          pend_d = 1'b0;
          if (cmd_q == CMD_RDTRAN) begin
            tgt_d = sym_ok ? tr_rdata : '0;
          end else begin
            lnk_d = lk_rdata; len_d = ln_rdata;
          end
        end
        if (!res_v_q || !res_stall_i) begin
          res_v_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // The read path latches data in S_FIN_RD, the state after S_RD_WAIT
    if (state_q == S_FIN_RD) begin
      if (cmd_q == CMD_RDTRAN) begin
        tgt_d = sym_ok ? tr_rdata : '0;
      end else begin
        lnk_d = lk_rdata; len_d = ln_rdata;
      end
      pend_d = 1'b0;
    end
    if (state_q == S_IDLE) begin
      pend_d = 1'b0;
    end
  end

  assign res_valid_o   = res_v_q;
  assign status_o      = st_q;
  assign target_node_o = tgt_q;
  assign link_node_o   = lnk_q;
  assign node_length_o = len_q;
  assign clone_made_o  = cm_q;
  assign clone_node_o  = cn_q;
  assign node_count_o  = cnt_q;

  `SAB_ASSERT(a_count_min, clk_i, rst_ni, cnt_q != '0, "node count dropped to zero")
  `SAB_ASSERT(a_no_accept_busy, clk_i, rst_ni, !(accept && state_q != S_IDLE),
              "request accepted while busy")
  `SAB_ASSERT_NEXT(a_clone_ok, clk_i, rst_ni, res_v_q && cm_q, st_q == ST_OK || !res_v_q,
                   "clone reported with error status")
  `SAB_ASSERT_NEXT(a_out_valid, clk_i, rst_ni, state_q == S_OUT && !res_v_q, res_v_q,
                   "result not raised after output state")
endmodule
`default_nettype wire
